FILE: rtl/core/i2c_brs_pkg.sv
package i2c_brs_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLAVE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_READ_BYTE_COUNT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_READ_TIMEOUT = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WRITE_TIMEOUT = 2'd3;

   // Request kinds.
   localparam logic [1:0] KIND_START_READ = 2'd0;
   localparam logic [1:0] KIND_START_WRITE = 2'd1;
   localparam logic [1:0] KIND_POLL = 2'd2;
   localparam logic [1:0] KIND_TICK = 2'd3;

   // Sequencer phases.
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ADDR = 2'd1;
   localparam logic [1:0] PH_RECV = 2'd2;
   localparam logic [1:0] PH_WRITE = 2'd3;

   // Commands to the bus master.
   localparam logic [2:0] CMD_NONE = 3'd0;
   localparam logic [2:0] CMD_ADDR_NOSTOP = 3'd1;
   localparam logic [2:0] CMD_RECV_STOP = 3'd2;
   localparam logic [2:0] CMD_REQ_STOP = 3'd3;
   localparam logic [2:0] CMD_WRITE_STOP = 3'd4;

   // Outcomes.
   localparam logic [2:0] OC_PENDING = 3'd0;
   localparam logic [2:0] OC_OK = 3'd1;
   localparam logic [2:0] OC_FAIL = 3'd2;
   localparam logic [2:0] OC_TIMEOUT = 3'd3;
   localparam logic [2:0] OC_REJECT = 3'd4;

   localparam logic [7:0] ADDR_PHASE_BYTES = 8'd1;
   localparam logic [7:0] WRITE_PHASE_BYTES = 8'd2;

   localparam logic [6:0] SLAVE_ADDRESS_RESET = 7'd0;
   localparam logic [7:0] READ_BYTE_COUNT_RESET = 8'd1;
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic bus_busy;
      logic stop_detected;
      logic access_ready;
      logic nack_seen;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] command;
      logic [6:0] target;
      logic [7:0] byte_count;
      logic [7:0] tx_first;
      logic [7:0] tx_second;
      logic clear_stop_flag;
      logic clear_nack_flag;
      logic done_res;
      logic [2:0] outcome;
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic [6:0] slave_address;
      logic [7:0] read_byte_count;
      logic [15:0] read_timeout_ticks;
      logic [15:0] write_timeout_ticks;
   } cfg_type;

endpackage

FILE: rtl/core/i2c_brs_csr.sv
module i2c_brs_csr
   import i2c_brs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SLAVE_ADDRESS: cfg_in.slave_address = csr_data[6:0];
            CSR_READ_BYTE_COUNT: cfg_in.read_byte_count = csr_data[7:0];
            CSR_READ_TIMEOUT: cfg_in.read_timeout_ticks = csr_data;
            CSR_WRITE_TIMEOUT: cfg_in.write_timeout_ticks = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address <= SLAVE_ADDRESS_RESET;
         cfg_ff.read_byte_count <= READ_BYTE_COUNT_RESET;
         cfg_ff.read_timeout_ticks <= TIMEOUT_RESET;
         cfg_ff.write_timeout_ticks <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/i2c_brs_engine.sv
module i2c_brs_engine
   import i2c_brs_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
)(
   input  logic clock,
   input  logic reset,
   input  logic fire,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp,
   output logic [1:0] phase
);

   logic [1:0] phase_ff;
   logic [1:0] phase_in;
   logic [COUNT_WIDTH-1:0] countdown_ff;
   logic [COUNT_WIDTH-1:0] countdown_in;
   logic [COUNT_WIDTH-1:0] countdown_dec;
   logic [6:0] target_ff;
   logic [6:0] target_in;

   assign countdown_dec = countdown_ff - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   always_comb begin
      rsp = '0;
      phase_in = phase_ff;
      countdown_in = countdown_ff;
      target_in = target_ff;
      case (req.kind)
         KIND_START_READ, KIND_START_WRITE: begin
            if (phase_ff != PH_IDLE || req.bus_busy) begin
               rsp.done_res = 1'b1;
               rsp.outcome = OC_REJECT;
            end else begin
               target_in = cfg.slave_address;
               rsp.target = cfg.slave_address;
               rsp.tx_first = req.reg_addr;
               if (req.kind == KIND_START_READ) begin
                  rsp.command = CMD_ADDR_NOSTOP;
                  rsp.byte_count = ADDR_PHASE_BYTES;
                  countdown_in = COUNT_WIDTH'(cfg.read_timeout_ticks);
                  phase_in = PH_ADDR;
               end else begin
                  rsp.command = CMD_WRITE_STOP;
                  rsp.byte_count = WRITE_PHASE_BYTES;
                  rsp.tx_second = req.write_data;
                  countdown_in = COUNT_WIDTH'(cfg.write_timeout_ticks);
                  phase_in = PH_WRITE;
               end
            end
         end
         KIND_POLL: begin
            if (phase_ff == PH_ADDR) begin
               // A stop while the address is still going out fails the read.
               if (req.stop_detected) begin
                  rsp.clear_stop_flag = 1'b1;
                  rsp.done_res = 1'b1;
                  rsp.outcome = OC_FAIL;
                  phase_in = PH_IDLE;
               end else if (req.access_ready) begin
                  if (req.nack_seen) begin
                     rsp.command = CMD_REQ_STOP;
                     rsp.clear_nack_flag = 1'b1;
                  end else begin
                     rsp.command = CMD_RECV_STOP;
                     rsp.target = target_ff;
                     rsp.byte_count = cfg.read_byte_count;
                     phase_in = PH_RECV;
                  end
               end
            end else if (phase_ff != PH_IDLE && req.stop_detected) begin
               rsp.clear_stop_flag = 1'b1;
               rsp.done_res = 1'b1;
               if (req.nack_seen) begin
                  rsp.clear_nack_flag = 1'b1;
                  rsp.outcome = OC_FAIL;
               end else begin
                  rsp.outcome = OC_OK;
                  if (phase_ff == PH_RECV) begin
                     rsp.read_data = req.rx_byte;
                  end
               end
               phase_in = PH_IDLE;
            end
         end
         default: begin
            // A countdown loaded as zero never expires.
            if (phase_ff != PH_IDLE && countdown_ff != '0) begin
               countdown_in = countdown_dec;
               if (countdown_dec == '0) begin
                  rsp.done_res = 1'b1;
                  rsp.outcome = OC_TIMEOUT;
                  phase_in = PH_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         countdown_ff <= '0;
         target_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         countdown_ff <= countdown_in;
         target_ff <= target_in;
      end
   end

   assign phase = phase_ff;

endmodule

FILE: rtl/core/i2c_byte_register_access_sequencer.sv
// Register read/write sequencer for a one-byte register access over an I2C master.
// Requests arrive on the req_ channel (valid/ready): a start read, a start write,
// a status poll carrying the master's flags, or a timer tick. Every request gives
// exactly one response on the rsp_ channel, in order, with the command to hand to
// the master, the flag clears to write, and the outcome once the access ends.
// The csr_ channel writes the slave address, receive byte count and the read and
// write timeouts; it is always ready and should only be written while idle.
// A request taken is registered, evaluated against the sequencer state, and its
// response is registered in turn. Throughput is one request per cycle while the
// receiver does not stall, set by the single evaluation stage that updates the
// phase and countdown registers.
// When the receiver stalls, the response register holds and the input register
// still fills, so one more request is taken before req_ready drops.
// A synchronous reset empties both registers, returns the sequencer to idle with
// a zero countdown, and restores the configuration to its reset values
// (address 0, byte count 1, both timeouts 100 ticks).
module i2c_byte_register_access_sequencer
   import i2c_brs_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
)(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_write_data,
   input  logic req_bus_busy,
   input  logic req_stop_detected,
   input  logic req_access_ready,
   input  logic req_nack_seen,
   input  logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_command,
   output logic [6:0] rsp_target,
   output logic [7:0] rsp_byte_count,
   output logic [7:0] rsp_tx_first,
   output logic [7:0] rsp_tx_second,
   output logic rsp_clear_stop_flag,
   output logic rsp_clear_nack_flag,
   output logic rsp_done_res,
   output logic [2:0] rsp_outcome,
   output logic [7:0] rsp_read_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data
);

   logic req_valid_ff;
   logic req_valid_in;
   req_type req_ff;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type step_rsp;
   cfg_type cfg;
   logic [1:0] phase;
   logic advance;
   logic fire;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign fire = req_valid_ff && advance;
   assign req_ready = !req_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign req_valid_in = req_ready ? req_valid : req_valid_ff;
   assign rsp_valid_in = advance ? fire : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.kind <= req_kind;
         req_ff.reg_addr <= req_reg_addr;
         req_ff.write_data <= req_write_data;
         req_ff.bus_busy <= req_bus_busy;
         req_ff.stop_detected <= req_stop_detected;
         req_ff.access_ready <= req_access_ready;
         req_ff.nack_seen <= req_nack_seen;
         req_ff.rx_byte <= req_rx_byte;
      end
      if (fire) begin
         rsp_ff <= step_rsp;
      end
   end

   i2c_brs_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cfg(cfg)
   );

   i2c_brs_engine #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .req(req_ff),
      .cfg(cfg),
      .rsp(step_rsp),
      .phase(phase)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_command = rsp_ff.command;
   assign rsp_target = rsp_ff.target;
   assign rsp_byte_count = rsp_ff.byte_count;
   assign rsp_tx_first = rsp_ff.tx_first;
   assign rsp_tx_second = rsp_ff.tx_second;
   assign rsp_clear_stop_flag = rsp_ff.clear_stop_flag;
   assign rsp_clear_nack_flag = rsp_ff.clear_nack_flag;
   assign rsp_done_res = rsp_ff.done_res;
   assign rsp_outcome = rsp_ff.outcome;
   assign rsp_read_data = rsp_ff.read_data;

   // A finished access always leaves the sequencer idle; a rejected start leaves
   // any pending access running.
   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      fire && step_rsp.done_res && step_rsp.outcome != OC_REJECT |=> phase == PH_IDLE)
      else $error("sequencer not idle after a finished access");

   // A response carries an outcome exactly when it ends the access.
   a_done_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_done_res == (rsp_outcome != OC_PENDING)))
      else $error("done flag and outcome disagree");

   // Read data is only returned by a successful access.
   a_read_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_data != 8'd0 |-> rsp_outcome == OC_OK)
      else $error("read data without success");

   // A held request is not lost while the response register is stalled.
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff)
      else $error("pending request dropped during stall");

endmodule
